// ----- src/field_oriented_current_control_macros.svh -----
// Assertion macros for the field-oriented current controller.
// Included by the RTL files that check their own sequencing; no other dependency.
`ifndef FIELD_ORIENTED_CURRENT_CONTROL_MACROS_SVH
`define FIELD_ORIENTED_CURRENT_CONTROL_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge out of reset
`define FOCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("focc assertion failed");
// Condition must never be seen out of reset
`define FOCC_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("focc forbidden condition seen");
`else
`define FOCC_ASSERT(lbl, clk, rst_n, prop)
`define FOCC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- src/focc_pkg.sv -----
// Shared types, constants and microcode for the field-oriented current controller.
// No dependencies; used by focc_mac, focc_seq and the top level.
`timescale 1ns / 1ps

package focc_pkg;

  localparam int BW      = 18;   // width of the B operand of the shared multiplier
  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd44;

  // Coefficients, B operand side
  localparam logic signed [BW-1:0] C_ONE    = 18'sd1;
  localparam logic signed [BW-1:0] C_TWO    = 18'sd2;
  localparam logic signed [BW-1:0] C_POLY_A = 18'sd51472;
  localparam logic signed [BW-1:0] C_POLY_B = 18'sd21024;
  localparam logic signed [BW-1:0] C_POLY_C = 18'sd2320;
  localparam logic signed [BW-1:0] C_SQRT3  = 18'sd56756;
  localparam logic signed [BW-1:0] C_HUNDRED = 18'sd100;
  localparam logic signed [BW-1:0] C_TWO_3RD = 18'sd43691;
  localparam logic signed [BW-1:0] C_ONE_3RD = 18'sd21845;
  localparam logic signed [BW-1:0] C_INV_SQ3 = 18'sd37837;
  localparam logic signed [BW-1:0] C_MON    = 18'sd130;

  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    A_ZS, A_ZC, A_ONE, A_Z2, A_T, A_IU, A_IV, A_IW, A_A2, A_B2, A_ID, A_IQ,
    A_ED, A_EQ, A_ACCEL, A_DSUM, A_QSUM, A_VD, A_VQ, A_VA, A_VB
  } a_sel_e;

  typedef enum logic [4:0] {
    B_ZS, B_ZC, B_Z2, B_ONE, B_SN, B_CS, B_PROP, B_INTEG, B_POLY_A, B_POLY_B,
    B_POLY_C, B_TWO, B_SQRT3, B_HUNDRED, B_TWO_3RD, B_ONE_3RD, B_INV_SQ3, B_MON
  } b_sel_e;

  typedef enum logic [2:0] {
    P_NONE, P_FLR15, P_RND8, P_RND15, P_RND16, P_RNDF
  } post_e;

  typedef enum logic [1:0] {
    S_NONE, S_SUM, S_DAT
  } sat_e;

  typedef enum logic [4:0] {
    D_NONE, D_Z2, D_T, D_SN, D_CS, D_A2, D_B2, D_ID, D_IQ, D_ED, D_EQ,
    D_DSUM, D_QSUM, D_VD, D_VQ, D_VA, D_VB, D_OU, D_OV, D_OW, D_OD, D_OQ
  } dst_e;

  typedef struct packed {
    a_sel_e a;
    b_sel_e b;
    logic   neg;   // subtract the product
    logic   clr;   // start a new sum
    post_e  post;
    sat_e   sat;
    dst_e   dst;
  } uop_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic wb_en;
    logic load;
    logic commit;
    uop_t uop;
  } ctrl_t;

  // Microcode: one multiply-accumulate per step, write back where dst is set
  function automatic uop_t ucode(input logic [STEP_W-1:0] idx);
    uop_t u;
    u = '{A_ONE, B_ONE, 1'b0, 1'b1, P_NONE, S_NONE, D_NONE};
    unique case (idx)
      // sine of the folded angle
      6'd0:  u = '{A_ZS,    B_ZS,      1'b0, 1'b1, P_FLR15, S_NONE, D_Z2};
      6'd1:  u = '{A_Z2,    B_POLY_C,  1'b0, 1'b1, P_FLR15, S_NONE, D_T};
      6'd2:  u = '{A_Z2,    B_POLY_B,  1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd3:  u = '{A_T,     B_Z2,      1'b1, 1'b0, P_FLR15, S_NONE, D_T};
      6'd4:  u = '{A_ONE,   B_POLY_A,  1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd5:  u = '{A_T,     B_ONE,     1'b1, 1'b0, P_NONE,  S_NONE, D_T};
      6'd6:  u = '{A_T,     B_ZS,      1'b0, 1'b1, P_FLR15, S_NONE, D_SN};
      // cosine, same polynomial
      6'd7:  u = '{A_ZC,    B_ZC,      1'b0, 1'b1, P_FLR15, S_NONE, D_Z2};
      6'd8:  u = '{A_Z2,    B_POLY_C,  1'b0, 1'b1, P_FLR15, S_NONE, D_T};
      6'd9:  u = '{A_Z2,    B_POLY_B,  1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd10: u = '{A_T,     B_Z2,      1'b1, 1'b0, P_FLR15, S_NONE, D_T};
      6'd11: u = '{A_ONE,   B_POLY_A,  1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd12: u = '{A_T,     B_ONE,     1'b1, 1'b0, P_NONE,  S_NONE, D_T};
      6'd13: u = '{A_T,     B_ZC,      1'b0, 1'b1, P_FLR15, S_NONE, D_CS};
      // Clarke
      6'd14: u = '{A_IU,    B_TWO,     1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd15: u = '{A_IV,    B_ONE,     1'b1, 1'b0, P_NONE,  S_NONE, D_NONE};
      6'd16: u = '{A_IW,    B_ONE,     1'b1, 1'b0, P_NONE,  S_NONE, D_A2};
      6'd17: u = '{A_IV,    B_SQRT3,   1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd18: u = '{A_IW,    B_SQRT3,   1'b1, 1'b0, P_RND15, S_NONE, D_B2};
      // Park
      6'd19: u = '{A_A2,    B_CS,      1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd20: u = '{A_B2,    B_SN,      1'b0, 1'b0, P_RND16, S_NONE, D_ID};
      6'd21: u = '{A_B2,    B_CS,      1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd22: u = '{A_A2,    B_SN,      1'b1, 1'b0, P_RND16, S_NONE, D_IQ};
      // errors and integrators
      6'd23: u = '{A_ID,    B_ONE,     1'b1, 1'b1, P_NONE,  S_NONE, D_ED};
      6'd24: u = '{A_ACCEL, B_HUNDRED, 1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd25: u = '{A_IQ,    B_ONE,     1'b1, 1'b0, P_NONE,  S_NONE, D_EQ};
      6'd26: u = '{A_DSUM,  B_ONE,     1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd27: u = '{A_ED,    B_ONE,     1'b0, 1'b0, P_NONE,  S_SUM,  D_DSUM};
      6'd28: u = '{A_QSUM,  B_ONE,     1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd29: u = '{A_EQ,    B_ONE,     1'b0, 1'b0, P_NONE,  S_SUM,  D_QSUM};
      // PI outputs
      6'd30: u = '{A_ED,    B_PROP,    1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd31: u = '{A_DSUM,  B_INTEG,   1'b0, 1'b0, P_RND8,  S_DAT,  D_VD};
      6'd32: u = '{A_EQ,    B_PROP,    1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd33: u = '{A_QSUM,  B_INTEG,   1'b0, 1'b0, P_RND8,  S_DAT,  D_VQ};
      // inverse Park
      6'd34: u = '{A_VD,    B_CS,      1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd35: u = '{A_VQ,    B_SN,      1'b1, 1'b0, P_RND15, S_NONE, D_VA};
      6'd36: u = '{A_VD,    B_SN,      1'b0, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd37: u = '{A_VQ,    B_CS,      1'b0, 1'b0, P_RND15, S_NONE, D_VB};
      // inverse Clarke
      6'd38: u = '{A_VA,    B_TWO_3RD, 1'b0, 1'b1, P_RND16, S_DAT,  D_OU};
      6'd39: u = '{A_VA,    B_ONE_3RD, 1'b1, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd40: u = '{A_VB,    B_INV_SQ3, 1'b0, 1'b0, P_RND16, S_DAT,  D_OV};
      6'd41: u = '{A_VA,    B_ONE_3RD, 1'b1, 1'b1, P_NONE,  S_NONE, D_NONE};
      6'd42: u = '{A_VB,    B_INV_SQ3, 1'b1, 1'b0, P_RND16, S_DAT,  D_OW};
      // monitor outputs
      6'd43: u = '{A_ID,    B_MON,     1'b0, 1'b1, P_RNDF,  S_DAT,  D_OD};
      6'd44: u = '{A_IQ,    B_MON,     1'b0, 1'b1, P_RNDF,  S_DAT,  D_OQ};
      default: u = '{A_ONE, B_ONE, 1'b0, 1'b1, P_NONE, S_NONE, D_NONE};
    endcase
    return u;
  endfunction

endpackage

// ----- src/focc_mac.sv -----
// Shared multiply-accumulate unit with rounding shift and saturation.
// Depends on focc_pkg for the control struct and the B operand width.
`timescale 1ns / 1ps

module focc_mac
  import focc_pkg::*;
#(
  parameter int DW = 16,
  parameter int SW = 32,
  parameter int RW = 33
) (
  input  logic                 clk_i,
  input  ctrl_t                ctrl_i,
  input  logic signed [RW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [RW-1:0] res_o
);

  localparam int PW   = RW + BW;
  localparam int ACCW = PW + 2;
  localparam int FRAC = DW - 5;

  localparam logic signed [ACCW-1:0] DHI = {{(ACCW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] DLO = ~DHI;
  localparam logic signed [ACCW-1:0] SHI = {{(ACCW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACCW-1:0] SLO = ~SHI;
  localparam logic signed [ACCW-1:0] H8  = {{(ACCW-8){1'b0}}, 1'b1, 7'd0};
  localparam logic signed [ACCW-1:0] H15 = {{(ACCW-15){1'b0}}, 1'b1, 14'd0};
  localparam logic signed [ACCW-1:0] H16 = {{(ACCW-16){1'b0}}, 1'b1, 15'd0};
  localparam logic signed [ACCW-1:0] HF  = {{(ACCW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   prod_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [ACCW-1:0] acc_d;
  logic signed [ACCW-1:0] rnd;
  logic signed [ACCW-1:0] satd;

  // Multiply stage, product registered
  assign prod = PW'(a_i) * PW'(b_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= ctrl_i.uop.neg ? -prod : prod;
    end
  end

  // Accumulate stage
  assign acc_d = (ctrl_i.uop.clr ? '0 : acc_q) + ACCW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  // Rescale: floor or round-half-up shift
  always_comb begin
    case (ctrl_i.uop.post)
      P_FLR15: rnd = acc_q >>> 15;
      P_RND8:  rnd = (acc_q + H8) >>> 8;
      P_RND15: rnd = (acc_q + H15) >>> 15;
      P_RND16: rnd = (acc_q + H16) >>> 16;
      P_RNDF:  rnd = (acc_q + HF) >>> FRAC;
      default: rnd = acc_q;
    endcase
  end

  // Clamp to the data or integrator range
  always_comb begin
    case (ctrl_i.uop.sat)
      S_DAT:   satd = (rnd > DHI) ? DHI : ((rnd < DLO) ? DLO : rnd);
      S_SUM:   satd = (rnd > SHI) ? SHI : ((rnd < SLO) ? SLO : rnd);
      default: satd = rnd;
    endcase
  end

  assign res_o = satd[RW-1:0];

endmodule

// ----- src/focc_seq.sv -----
// Microcode sequencer: steps the shared MAC through one control period.
// Depends on focc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "field_oriented_current_control_macros.svh"

module focc_seq
  import focc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_fire_i,
  input  logic  out_free_i,
  output logic  busy_o,
  output ctrl_t ctrl_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_WB   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  uop_t              uop;
  logic [2:0]        phase_vec;

  assign uop = ucode(step_q);

  // Advance through multiply, accumulate and writeback phases
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ctrl_o  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, uop};
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          ctrl_o.load = 1'b1;
          step_d      = '0;
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl_o.mul_en = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        ctrl_o.acc_en = 1'b1;
        if (uop.dst != D_NONE) begin
          state_d = ST_WB;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_WB: begin
        ctrl_o.wb_en = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign phase_vec = {ctrl_o.mul_en, ctrl_o.acc_en, ctrl_o.wb_en};

  `FOCC_NEVER(a_step_range, clk_i, rst_ni, step_q > LAST_STEP)
  `FOCC_ASSERT(a_phase_onehot, clk_i, rst_ni, $onehot0(phase_vec))
  `FOCC_ASSERT(a_load_start, clk_i, rst_ni, ctrl_o.load |=> state_q == ST_MUL && step_q == '0)

endmodule

// ----- src/field_oriented_current_control.sv -----
// Top level of the field-oriented PI current controller.
// Depends on focc_pkg, focc_mac and focc_seq.
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+------------------------
//   in      | phase_*_current_i, rotor_angle_i, accel  | in_valid_i / in_stall_o
//   out     | phase_*_voltage_o, d/q_monitor_o         | out_valid_o / out_stall_i
//   cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i         | write enable only
//
// Each beat runs 45 MAC steps, each a multiply phase and an accumulate phase, 27 of
// them followed by a writeback phase, and then a commit; the single shared multiplier
// sets the pace, and no new beat is taken before the previous one is committed.
// in_stall_o is high from acceptance until the result is committed to the output
// register; a stalled output beat delays that commit. Reset clears the sequencer,
// the integrators, the gains (to 1.0 and 0) and the output valid.
`timescale 1ns / 1ps

module field_oriented_current_control
  import focc_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int ANGLE_BITS = 16,
  parameter int SUM_WIDTH  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] phase_u_current_i,
  input  logic signed [DATA_WIDTH-1:0] phase_v_current_i,
  input  logic signed [DATA_WIDTH-1:0] phase_w_current_i,
  input  logic        [ANGLE_BITS-1:0] rotor_angle_i,
  input  logic signed [DATA_WIDTH-1:0] accel_command_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] phase_u_voltage_o,
  output logic signed [DATA_WIDTH-1:0] phase_v_voltage_o,
  output logic signed [DATA_WIDTH-1:0] phase_w_voltage_o,
  output logic signed [DATA_WIDTH-1:0] d_monitor_o,
  output logic signed [DATA_WIDTH-1:0] q_monitor_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [GAIN_W-1:0]            cfg_wdata_i
);

  localparam int RW = ((SUM_WIDTH > DATA_WIDTH + 8) ? SUM_WIDTH : DATA_WIDTH + 8) + 1;

  ctrl_t ctrl;
  logic  busy;
  logic  in_fire;
  logic  out_free;
  logic  out_valid_q;

  logic [GAIN_W-1:0] prop_q, integ_q;

  logic [15:0] ang16, angc;
  logic [14:0] zr_s, zr_c;
  logic        neg_s_q, neg_c_q;

  logic signed [RW-1:0] a_val, res;
  logic signed [BW-1:0] b_val;

  logic signed [RW-1:0] zs_q, zc_q, z2_q, t_q, sn_q, cs_q;
  logic signed [RW-1:0] iu_q, iv_q, iw_q, accel_q;
  logic signed [RW-1:0] a2_q, b2_q, id_q, iq_q, ed_q, eq_q, dsum_q, qsum_q;
  logic signed [RW-1:0] vd_q, vq_q, va_q, vb_q;
  logic signed [RW-1:0] ou_q, ov_q, ow_q, od_q, oq_q;

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= GAIN_W'(256);
      integ_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_PROP) begin
        prop_q <= cfg_wdata_i;
      end else if (cfg_idx_i == REG_INTEG) begin
        integ_q <= cfg_wdata_i;
      end
    end
  end

  // Bring the angle to a 16-bit turn
  if (ANGLE_BITS >= 16) begin : g_ang_trunc
    assign ang16 = rotor_angle_i[ANGLE_BITS-1 -: 16];
  end else begin : g_ang_pad
    assign ang16 = {rotor_angle_i, {(16-ANGLE_BITS){1'b0}}};
  end

  // Fold sine and cosine angles onto the first quadrant
  assign angc = ang16 + 16'd16384;
  assign zr_s = ang16[14] ? (15'd16384 - {1'b0, ang16[13:0]}) : {1'b0, ang16[13:0]};
  assign zr_c = angc[14]  ? (15'd16384 - {1'b0, angc[13:0]})  : {1'b0, angc[13:0]};

  focc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  // A operand select
  always_comb begin
    case (ctrl.uop.a)
      A_ZS:    a_val = zs_q;
      A_ZC:    a_val = zc_q;
      A_ONE:   a_val = RW'(1);
      A_Z2:    a_val = z2_q;
      A_T:     a_val = t_q;
      A_IU:    a_val = iu_q;
      A_IV:    a_val = iv_q;
      A_IW:    a_val = iw_q;
      A_A2:    a_val = a2_q;
      A_B2:    a_val = b2_q;
      A_ID:    a_val = id_q;
      A_IQ:    a_val = iq_q;
      A_ED:    a_val = ed_q;
      A_EQ:    a_val = eq_q;
      A_ACCEL: a_val = accel_q;
      A_DSUM:  a_val = dsum_q;
      A_QSUM:  a_val = qsum_q;
      A_VD:    a_val = vd_q;
      A_VQ:    a_val = vq_q;
      A_VA:    a_val = va_q;
      A_VB:    a_val = vb_q;
      default: a_val = '0;
    endcase
  end

  // B operand select: small registers, gains and coefficients
  always_comb begin
    case (ctrl.uop.b)
      B_ZS:      b_val = zs_q[BW-1:0];
      B_ZC:      b_val = zc_q[BW-1:0];
      B_Z2:      b_val = z2_q[BW-1:0];
      B_ONE:     b_val = C_ONE;
      B_SN:      b_val = sn_q[BW-1:0];
      B_CS:      b_val = cs_q[BW-1:0];
      B_PROP:    b_val = {2'b00, prop_q};
      B_INTEG:   b_val = {2'b00, integ_q};
      B_POLY_A:  b_val = C_POLY_A;
      B_POLY_B:  b_val = C_POLY_B;
      B_POLY_C:  b_val = C_POLY_C;
      B_TWO:     b_val = C_TWO;
      B_SQRT3:   b_val = C_SQRT3;
      B_HUNDRED: b_val = C_HUNDRED;
      B_TWO_3RD: b_val = C_TWO_3RD;
      B_ONE_3RD: b_val = C_ONE_3RD;
      B_INV_SQ3: b_val = C_INV_SQ3;
      B_MON:     b_val = C_MON;
      default:   b_val = '0;
    endcase
  end

  focc_mac #(
    .DW (DATA_WIDTH),
    .SW (SUM_WIDTH),
    .RW (RW)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .a_i    (a_val),
    .b_i    (b_val),
    .res_o  (res)
  );

  // Capture the input beat and the folded angles
  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      iu_q    <= RW'(phase_u_current_i);
      iv_q    <= RW'(phase_v_current_i);
      iw_q    <= RW'(phase_w_current_i);
      accel_q <= RW'(accel_command_i);
      zs_q    <= {{(RW-16){1'b0}}, zr_s, 1'b0};
      zc_q    <= {{(RW-16){1'b0}}, zr_c, 1'b0};
      neg_s_q <= ang16[15];
      neg_c_q <= angc[15];
    end
  end

  // Write back MAC results into the working registers
  always_ff @(posedge clk_i) begin
    if (ctrl.wb_en) begin
      case (ctrl.uop.dst)
        D_Z2: z2_q <= res;
        D_T:  t_q  <= res;
        D_SN: sn_q <= neg_s_q ? -res : res;
        D_CS: cs_q <= neg_c_q ? -res : res;
        D_A2: a2_q <= res;
        D_B2: b2_q <= res;
        D_ID: id_q <= res;
        D_IQ: iq_q <= res;
        D_ED: ed_q <= res;
        D_EQ: eq_q <= res;
        D_VD: vd_q <= res;
        D_VQ: vq_q <= res;
        D_VA: va_q <= res;
        D_VB: vb_q <= res;
        D_OU: ou_q <= res;
        D_OV: ov_q <= res;
        D_OW: ow_q <= res;
        D_OD: od_q <= res;
        D_OQ: oq_q <= res;
        default: ;
      endcase
    end
  end

  // Integrators, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dsum_q <= '0;
      qsum_q <= '0;
    end else if (ctrl.wb_en) begin
      if (ctrl.uop.dst == D_DSUM) begin
        dsum_q <= res;
      end
      if (ctrl.uop.dst == D_QSUM) begin
        qsum_q <= res;
      end
    end
  end

  // Output register: load on commit, drop valid when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      phase_u_voltage_o <= ou_q[DATA_WIDTH-1:0];
      phase_v_voltage_o <= ov_q[DATA_WIDTH-1:0];
      phase_w_voltage_o <= ow_q[DATA_WIDTH-1:0];
      d_monitor_o       <= od_q[DATA_WIDTH-1:0];
      q_monitor_o       <= oq_q[DATA_WIDTH-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- sim/tb_field_oriented_current_control.sv -----
// Testbench for the field-oriented PI current controller: random and directed beats,
// a bit-exact predictor of the control period, and gain changes between phases.
// Depends on focc_pkg and field_oriented_current_control.
`timescale 1ns / 1ps

module tb_field_oriented_current_control;
  import focc_pkg::*;

  localparam int  RUN_LIMIT    = 3000000;
  localparam int  LONG_HOLD    = 3000;
  localparam int  SETTLE       = 130;
  localparam int  PHASE_ITEMS  = 305;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic signed [15:0] iu;
    logic signed [15:0] iv;
    logic signed [15:0] iw;
    logic        [15:0] ang;
    logic signed [15:0] accel;
  } current_beat_t;

  typedef struct {
    logic signed [15:0] vu;
    logic signed [15:0] vv;
    logic signed [15:0] vw;
    logic signed [15:0] dmon;
    logic signed [15:0] qmon;
  } drive_beat_t;

  // Predict one control period per accepted beat and hold the expected drives
  class drive_scoreboard;
    longint      prop_gain;
    longint      integ_gain;
    longint      d_sum;
    longint      q_sum;
    drive_beat_t drive_q[$];
    int          errors;

    function new();
      prop_gain  = 256;
      integ_gain = 0;
      d_sum      = 0;
      q_sum      = 0;
      errors     = 0;
    endfunction

    function void write_gain(logic [1:0] idx, logic [15:0] value);
      if (idx == REG_PROP) prop_gain = longint'(value);
      else if (idx == REG_INTEG) integ_gain = longint'(value);
    endfunction

    function longint round_shift(longint x, int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint clip(longint x, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    // Quadrant-folded polynomial sine, Q1.15
    function longint sine(longint a);
      longint quad, r, z, z2, t, v;
      a    = a & 65535;
      quad = a >> 14;
      r    = a & 16383;
      if (quad & 1) r = 16384 - r;
      z  = r * 2;
      z2 = (z * z) >> 15;
      t  = (longint'(C_POLY_C) * z2) >> 15;
      t  = ((longint'(C_POLY_B) - t) * z2) >> 15;
      t  = longint'(C_POLY_A) - t;
      v  = (t * z) >> 15;
      return (quad & 2) ? -v : v;
    endfunction

    function void note_current(current_beat_t b);
      longint sn, cs, a2, b2, id, iq, ed, eq, vd, vq, va, vb;
      longint vu, vv, vw;
      drive_beat_t e;
      sn = sine(longint'(b.ang));
      cs = sine(longint'(b.ang) + 16384);
      a2 = 2 * longint'(b.iu) - longint'(b.iv) - longint'(b.iw);
      b2 = round_shift((longint'(b.iv) - longint'(b.iw)) * longint'(C_SQRT3), 15);
      id = round_shift(a2 * cs + b2 * sn, 16);
      iq = round_shift(b2 * cs - a2 * sn, 16);
      ed = -id;
      eq = longint'(b.accel) * 100 - iq;
      d_sum = clip(d_sum + ed, 32);
      q_sum = clip(q_sum + eq, 32);
      vd = clip(round_shift(prop_gain * ed + integ_gain * d_sum, 8), 16);
      vq = clip(round_shift(prop_gain * eq + integ_gain * q_sum, 8), 16);
      va = round_shift(vd * cs - vq * sn, 15);
      vb = round_shift(vd * sn + vq * cs, 15);
      vu = round_shift(va * longint'(C_TWO_3RD), 16);
      vv = round_shift(-va * longint'(C_ONE_3RD) + vb * longint'(C_INV_SQ3), 16);
      vw = round_shift(-va * longint'(C_ONE_3RD) - vb * longint'(C_INV_SQ3), 16);
      e.vu   = 16'(clip(vu, 16));
      e.vv   = 16'(clip(vv, 16));
      e.vw   = 16'(clip(vw, 16));
      e.dmon = 16'(clip(round_shift(id * 130, 11), 16));
      e.qmon = 16'(clip(round_shift(iq * 130, 11), 16));
      drive_q.push_back(e);
    endfunction

    task report(string what, logic signed [15:0] got, logic signed [15:0] want);
      errors++;
      $display("%0t: %s got %0d, want %0d", $time, what, got, want);
    endtask

    task check_drive(drive_beat_t r);
      drive_beat_t e;
      if (drive_q.size() == 0) begin
        report("unexpected drive beat, vu", r.vu, 16'sd0);
        return;
      end
      e = drive_q.pop_front();
      if (r.vu !== e.vu) report("phase_u_voltage", r.vu, e.vu);
      if (r.vv !== e.vv) report("phase_v_voltage", r.vv, e.vv);
      if (r.vw !== e.vw) report("phase_w_voltage", r.vw, e.vw);
      if (r.dmon !== e.dmon) report("d_monitor", r.dmon, e.dmon);
      if (r.qmon !== e.qmon) report("q_monitor", r.qmon, e.qmon);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i, in_stall_o;
  logic signed [15:0] phase_u_current_i, phase_v_current_i, phase_w_current_i;
  logic        [15:0] rotor_angle_i;
  logic signed [15:0] accel_command_i;
  logic out_valid_o, out_stall_i;
  logic signed [15:0] phase_u_voltage_o, phase_v_voltage_o, phase_w_voltage_o;
  logic signed [15:0] d_monitor_o, q_monitor_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [GAIN_W-1:0] cfg_wdata_i;

  drive_scoreboard sb = new();
  drive_beat_t     seen;
  bit              hold_req;
  int              hold_left;
  int              seg_left;
  int              stall_pct;
  int              cycles;

  field_oriented_current_control dut (.*);

  // Clock, 4 ns period
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check each accepted drive beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.vu   = phase_u_voltage_o;
      seen.vv   = phase_v_voltage_o;
      seen.vw   = phase_w_voltage_o;
      seen.dmon = d_monitor_o;
      seen.qmon = q_monitor_o;
      sb.check_drive(seen);
    end
  end

  // Receiver stall: segments of varying density, plus one long hold on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(400, 20);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end
      seg_left--;
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one current beat and hold it until accepted
  task send_current(current_beat_t b);
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    phase_u_current_i <= b.iu;
    phase_v_current_i <= b.iv;
    phase_w_current_i <= b.iw;
    rotor_angle_i     <= b.ang;
    accel_command_i   <= b.accel;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
      @(negedge clk_i);
    end
    sb.note_current(b);
  endtask

  task idle_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Drop valid and wait out every outstanding drive beat
  task drain();
    idle_sender(1);
    while (sb.drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task write_gain(logic [1:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_gain(idx, value);
  endtask

  function automatic current_beat_t pick_current();
    current_beat_t b;
    b.ang = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      b.iu    = 16'($urandom);
      b.iv    = 16'($urandom);
      b.iw    = 16'($urandom);
      b.accel = 16'($urandom);
    end else begin
      b.iu    = 16'($urandom_range(8000) - 4000);
      b.iv    = 16'($urandom_range(8000) - 4000);
      b.iw    = 16'($urandom_range(8000) - 4000);
      b.accel = 16'($urandom_range(600) - 300);
    end
    return b;
  endfunction

  function automatic current_beat_t beat(int iu, int iv, int iw, int ang, int accel);
    current_beat_t b;
    b.iu    = 16'(iu);
    b.iv    = 16'(iv);
    b.iw    = 16'(iw);
    b.ang   = 16'(ang);
    b.accel = 16'(accel);
    return b;
  endfunction

  // Random beats in bursts with gaps of random length, an optional long hold and pause
  task random_phase(int n, bit with_hold, bit with_pause);
    int sent;
    int burst;
    bit held;
    bit paused;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (sent < n) begin
      if (with_hold && !held && sent >= n / 3) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (with_pause && !paused && sent >= n / 2) begin
        drain();
        paused = 1'b1;
      end
      burst = $urandom_range(8, 1);
      repeat (burst) begin
        send_current(pick_current());
        sent++;
      end
      if ($urandom_range(2) != 0) idle_sender($urandom_range(130));
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    phase_u_current_i = '0;
    phase_v_current_i = '0;
    phase_w_current_i = '0;
    rotor_angle_i     = '0;
    accel_command_i   = '0;
    out_stall_i       = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_PROP;
    cfg_wdata_i       = '0;
    hold_req          = 1'b0;
    hold_left         = 0;
    seg_left          = 0;
    stall_pct         = 0;
    cycles            = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, quadrant angles, accel limits, integrator runaway
    send_current(beat(0, 0, 0, 0, 0));
    send_current(beat(32767, 32767, 32767, 0, 32767));
    send_current(beat(-32768, -32768, -32768, 65535, -32768));
    send_current(beat(32767, -32768, 32767, 16384, 0));
    send_current(beat(-32768, 32767, -32768, 32768, 1));
    send_current(beat(32767, -32768, -32768, 49152, -1));
    send_current(beat(2048, -1024, -1024, 16383, 10));
    send_current(beat(2048, -1024, -1024, 8192, -10));
    send_current(beat(-1, 1, 0, 1, 327));
    send_current(beat(0, 32767, -32768, 40000, -328));
    send_current(beat(1000, 2000, -3000, 24576, 0));
    drain();
    write_gain(REG_INTEG, 16'hFFFF);
    write_gain(REG_PROP, 16'hFFFF);
    send_current(beat(-32768, 32767, 32767, 0, 32767));
    send_current(beat(-32768, 32767, 32767, 0, 32767));
    send_current(beat(32767, -32768, -32768, 32768, -32768));
    send_current(beat(0, 0, 0, 57344, 32767));
    send_current(beat(0, 0, 0, 57344, 32767));
    drain();

    // Spare indexes must leave the gains alone
    write_gain(REG_SPARE_A, 16'h1234);
    write_gain(REG_SPARE_B, 16'h0000);
    send_current(beat(500, -250, -250, 12345, 5));
    drain();

    // Reset gains, then a series of gain settings
    write_gain(REG_PROP, 16'd256);
    write_gain(REG_INTEG, 16'd0);
    random_phase(PHASE_ITEMS, 1'b1, 1'b0);
    drain();
    write_gain(REG_PROP, 16'd0);
    write_gain(REG_INTEG, 16'd0);
    random_phase(PHASE_ITEMS, 1'b0, 1'b1);
    drain();
    write_gain(REG_PROP, 16'hFFFF);
    write_gain(REG_INTEG, 16'hFFFF);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    drain();
    write_gain(REG_PROP, 16'd256);
    write_gain(REG_INTEG, 16'd16);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    drain();
    write_gain(REG_PROP, 16'($urandom));
    write_gain(REG_INTEG, 16'($urandom));
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    drain();
    write_gain(REG_PROP, 16'd1);
    write_gain(REG_INTEG, 16'd1);
    random_phase(PHASE_ITEMS, 1'b0, 1'b0);
    drain();

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
